// ===== hdl/tfld_pkg.sv =====
// Shared types and constants for the tilt FIR / LED dither block.
// No dependencies; used by tfld_taps and tilt_fir_led_dither.
package tfld_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int WEIGHT_W   = 16;
	localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
	localparam int FILT_W     = 14;
	localparam int Q_SHIFT    = 16;
	localparam int LED_W      = 8;
	localparam int LEVEL_W    = 5;
	localparam int SEL_W      = 3;
	localparam int NUM_REGS   = 5;
	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sh3333;
	localparam logic signed [FILT_W:0]     LEVEL_OFFSET = -15'sd32;
	localparam int                         OUT_MAX      = 8191;
	localparam int                         OUT_MIN      = -8192;
	localparam logic [LED_W-1:0]           LED_SEED     = 8'h08;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [FILT_W-1:0] filtered;
		logic [LED_W-1:0]         led_drive;
	} result_t;

	typedef struct packed {
		logic                  wr;
		logic [REG_IDX_W-1:0]  idx;
		logic [WEIGHT_W-1:0]   data;
	} cfg_wr_t;

endpackage

// ===== hdl/tfld_taps.sv =====
// Tap weight registers, sample delay line and per-tap product register.
// Depends on tfld_pkg.
module tfld_taps #(
	parameter int TAPS = 5
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  tfld_pkg::cfg_wr_t                        cfg,
	output logic [tfld_pkg::APB_DATA_W-1:0]          rd_data,
	input  logic                                     load,
	input  tfld_pkg::item_t                          item,
	output logic signed [tfld_pkg::PROD_W-1:0]       prod_s1 [TAPS]
);

	logic signed [tfld_pkg::WEIGHT_W-1:0] weight_q [TAPS];
	logic signed [tfld_pkg::SAMPLE_W-1:0] delay_q  [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) weight_q[i] <= tfld_pkg::WEIGHT_RESET;
		end else if (cfg.wr) begin
			for (int i = 0; i < TAPS; i++) begin
				if (i < tfld_pkg::NUM_REGS && 32'(cfg.idx) == i)
					weight_q[i] <= cfg.data;
			end
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < TAPS; i++) begin
			if (i < tfld_pkg::NUM_REGS && 32'(cfg.idx) == i)
				rd_data = tfld_pkg::APB_DATA_W'(weight_q[i]);
		end
	end

	// Products use the line before the shift: the result lags one sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) delay_q[i] <= '0;
		end else if (load && item.cmd == tfld_pkg::CMD_SAMPLE) begin
			for (int i = 0; i < TAPS - 1; i++) delay_q[i] <= delay_q[i+1];
			delay_q[TAPS-1] <= item.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < TAPS; i++)
				prod_s1[i] <= tfld_pkg::PROD_W'(weight_q[i]) * tfld_pkg::PROD_W'(delay_q[i]);
		end
	end

endmodule

// ===== hdl/tilt_fir_led_dither.sv =====
// Top level of the tilt FIR / LED dither block: handshakes, APB port,
// sum and LED/dither state. Depends on tfld_pkg and tfld_taps.
//
//  channel  | signals                                    | payload
//  ---------+--------------------------------------------+------------------
//  item     | item_valid, item_ready                     | tfld_pkg::item_t
//  result   | result_valid, result_ready                 | tfld_pkg::result_t
//  config   | psel, penable, pwrite, paddr, pwdata,      | 16-bit tap weights
//           | prdata, pready                             | at 4*i
//
// One item per cycle sustained while result_ready is high. Stage 1 registers
// the TAPS products, stage 2 adds them, saturates, and updates the LED/dither
// state, whose registers are the result beat.
// The delay line shifts at accept; stage 2 takes items in order, so a tick
// always sees the pattern of the sample ahead of it.
// Reset clears all state but the stage 1 products and command; weights
// reset to 0x3333. A stall holds stage 2, then stage 1, then the item channel.
module tilt_fir_led_dither #(
	parameter int TAPS         = 5,
	parameter int DITHER_LIMIT = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  tfld_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output tfld_pkg::result_t                     result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tfld_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [tfld_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [tfld_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	// Sum width grows with the tap count; keep at least a 14-bit shifted sum.
	localparam int ACC_W = tfld_pkg::PROD_W + 2 + $clog2(TAPS);
	localparam int R_W   = ACC_W - tfld_pkg::Q_SHIFT;
	localparam logic signed [R_W-1:0] SAT_MAX = R_W'(tfld_pkg::OUT_MAX);
	localparam logic signed [R_W-1:0] SAT_MIN = R_W'(tfld_pkg::OUT_MIN);

	tfld_pkg::cfg_wr_t cfg;
	logic signed [tfld_pkg::PROD_W-1:0] prod_s1 [TAPS];

	logic v_s1_q, v_s2_q, cmd_s1;
	logic accept, s2_take;

	logic signed [tfld_pkg::FILT_W-1:0]   filt_q;
	logic [tfld_pkg::LED_W-1:0]           pattern_q, drive_q;
	logic [tfld_pkg::LEVEL_W-1:0]         level_q, count_q;

	logic signed [ACC_W-1:0]              acc;
	logic signed [R_W-1:0]                r;
	logic signed [tfld_pkg::FILT_W-1:0]   filt_d;
	logic signed [tfld_pkg::FILT_W:0]     lvl_v;
	logic [2*tfld_pkg::LED_W-1:0]         rot;
	logic [tfld_pkg::LED_W-1:0]           pattern_d;

	// APB: writes land on the access cycle, no wait states.
	assign pready    = 1'b1;
	assign cfg.wr    = psel && penable && pwrite;
	assign cfg.idx   = paddr[tfld_pkg::APB_ADDR_W-1:2];
	assign cfg.data  = pwdata[tfld_pkg::WEIGHT_W-1:0];

	// Advance stage 2 when it is empty or its beat leaves; stage 1 follows.
	assign s2_take    = v_s1_q && (!v_s2_q || result_ready);
	assign item_ready = !v_s1_q || s2_take;
	assign accept     = item_valid && item_ready;

	tfld_taps #(.TAPS(TAPS)) u_taps (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rd_data (prdata),
		.load    (accept),
		.item    (item),
		.prod_s1 (prod_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (accept)       v_s1_q <= 1'b1;
			else if (s2_take) v_s1_q <= 1'b0;
			if (s2_take)           v_s2_q <= 1'b1;
			else if (result_ready) v_s2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_s1 <= item.cmd;
	end

	// Sum the products, shift right by 16 (arithmetic) and saturate.
	always_comb begin
		acc = '0;
		for (int i = 0; i < TAPS; i++) acc = acc + ACC_W'(prod_s1[i]);
		r = acc[ACC_W-1:tfld_pkg::Q_SHIFT];
		if (r > SAT_MAX)      filt_d = tfld_pkg::FILT_W'(SAT_MAX);
		else if (r < SAT_MIN) filt_d = tfld_pkg::FILT_W'(SAT_MIN);
		else                  filt_d = r[tfld_pkg::FILT_W-1:0];
	end

	// Offset the result; bits 8:6 rotate the seed right, bits 5:1 set the level.
	assign lvl_v     = (tfld_pkg::FILT_W+1)'(filt_d) + tfld_pkg::LEVEL_OFFSET;
	assign rot       = {tfld_pkg::LED_SEED, tfld_pkg::LED_SEED} >> lvl_v[8:6];
	assign pattern_d = rot[tfld_pkg::LED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q    <= '0;
			pattern_q <= '0;
			level_q   <= '0;
			count_q   <= '0;
			drive_q   <= '0;
		end else if (s2_take) begin
			if (cmd_s1 == tfld_pkg::CMD_SAMPLE) begin
				filt_q    <= filt_d;
				pattern_q <= pattern_d;
				level_q   <= lvl_v[5:1];
			end else begin
				// Dim by one LED position while the counter is below the level.
				drive_q <= (count_q < level_q) ? (pattern_q >> 1) : pattern_q;
				if (count_q > tfld_pkg::LEVEL_W'(DITHER_LIMIT)) count_q <= '0;
				else                                              count_q <= count_q + 1'b1;
			end
		end
	end

	assign result_valid     = v_s2_q;
	assign result.filtered  = filt_q;
	assign result.led_drive = drive_q;

	a_pattern_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pattern_q)) else $error("LED pattern has more than one bit set");

	a_drive_from_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		s2_take && cmd_s1 == tfld_pkg::CMD_TICK |=>
		drive_q == pattern_q || drive_q == (pattern_q >> 1))
		else $error("LED drive not derived from pattern");

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s2_take |=> result_valid) else $error("stage 2 advance without result beat");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q && !result_ready && v_s1_q |=> v_s1_q && $stable(cmd_s1))
		else $error("stage 1 lost an item during an output stall");

endmodule
